### hw/rtl/kvcfg_pkg.sv
// Shared types and character constants for the key/value config byte parser.
// No dependencies; imported by kvcfg_parser, key_value_config_byte_parser and tb_top.
package kvcfg_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       value_valid;
      logic       value_end;
      logic       syntax_error;
      logic       text_done;
      logic       text_ok;
   } rsp_type;

   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_UNDER     = 8'h5F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam logic [3:0] KEY_LENGTH = 4'd8;
   localparam logic [3:0] KEY_LENGTH_MAX = 4'd15;

   // Expected key, one character per position
   function automatic logic [7:0] key_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = 8'h64;  // d
         3'd1: ch = 8'h61;  // a
         3'd2: ch = 8'h74;  // t
         3'd3: ch = 8'h61;  // a
         3'd4: ch = 8'h5F;  // _
         3'd5: ch = 8'h64;  // d
         3'd6: ch = 8'h69;  // i
         3'd7: ch = 8'h72;  // r
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CHAR_UNDER);
   endfunction

endpackage

### hw/rtl/key_value_config_byte_parser.sv
// Top level of the key/value config byte parser: input register, parser, result register.
// Depends on kvcfg_pkg and kvcfg_parser.
//
//   channel   ports                          direction   contents
//   req       req_valid req_stall req_data   in          text byte, last-byte mark
//   rsp       rsp_valid rsp_stall rsp_data   out         value byte, marks, error, verdict
//
// One byte per cycle sustained while rsp_stall is low; a result passes the input register, then the result register.
// A byte is parsed as it moves from the input register to the result register,
// so the parser state updates once per transaction, in order.
// Reset is synchronous and clears both valid flags and the parser state.
// A stalled result holds; the input register still fills, then req_stall rises.
module key_value_config_byte_parser
   import kvcfg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_result;
   logic    advance, req_take;

   // Move the held byte forward whenever the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   kvcfg_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      if (advance) out_data_ff <= step_result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### hw/rtl/kvcfg_parser.sv
// Parser state and per-byte transition logic for the key/value config parser.
// Depends on kvcfg_pkg for item types, character classes and the key table.
module kvcfg_parser
   import kvcfg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_COMMENT    = 3'd1,
      PH_KEY        = 3'd2,
      PH_WANT_EQ    = 3'd3,
      PH_WANT_VALUE = 3'd4,
      PH_BARE       = 3'd5,
      PH_QUOTED     = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in, phase_new;
   logic [3:0] key_len_ff, key_len_in, key_len_new;
   logic       key_match_ff, key_match_in, key_match_new;
   logic       error_ff, error_in, error_new;

   logic [7:0] c;
   logic       valid, done_end, bad, blank, word, key_good;
   logic [3:0] key_len_base;
   logic       key_match_base;

   assign c        = item.text_byte;
   assign blank    = is_blank(c);
   assign word     = is_word(c);
   assign key_good = key_match_ff && (key_len_ff == KEY_LENGTH);

   // A new key restarts the count; otherwise extend the running one
   assign key_len_base   = (phase_ff == PH_IDLE) ? 4'd0 : key_len_ff;
   assign key_match_base = (phase_ff == PH_IDLE) ? 1'b1 : key_match_ff;

   always_comb begin
      phase_new     = phase_ff;
      key_len_new   = key_len_ff;
      key_match_new = key_match_ff;
      valid         = 1'b0;
      done_end      = 1'b0;
      bad           = 1'b0;
      if (!error_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (blank) begin
               end else if (c == CHAR_HASH) begin
                  phase_new = PH_COMMENT;
               end else if (word) begin
                  phase_new = PH_KEY;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (c == CHAR_NEWLINE) phase_new = PH_IDLE;
            end
            PH_KEY: begin
               if (word) begin
               end else if (blank || c == CHAR_EQUAL) begin
                  if (!key_good) bad = 1'b1;
                  else phase_new = (c == CHAR_EQUAL) ? PH_WANT_VALUE : PH_WANT_EQ;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_WANT_EQ: begin
               if (blank) begin
               end else if (c == CHAR_EQUAL) begin
                  phase_new = PH_WANT_VALUE;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_WANT_VALUE: begin
               if (blank) begin
               end else if (c == CHAR_QUOTE) begin
                  phase_new = PH_QUOTED;
               end else if (word) begin
                  valid     = 1'b1;
                  phase_new = PH_BARE;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_BARE: begin
               if (word) begin
                  valid = 1'b1;
               end else if (blank) begin
                  done_end  = 1'b1;
                  phase_new = PH_IDLE;
               end else if (c == CHAR_HASH) begin
                  done_end  = 1'b1;
                  phase_new = PH_COMMENT;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (c == CHAR_QUOTE) begin
                  done_end  = 1'b1;
                  phase_new = PH_IDLE;
               end else if (c == CHAR_NEWLINE || c == CHAR_BACKSLASH) begin
                  bad = 1'b1;
               end else begin
                  valid = 1'b1;
               end
            end
            default: bad = 1'b1;
         endcase

         // Key byte taken in idle (new key) or in the key phase
         if (word && (phase_ff == PH_IDLE || phase_ff == PH_KEY)) begin
            key_match_new = key_match_base &&
                            (key_len_base < KEY_LENGTH) &&
                            (key_char(key_len_base[2:0]) == c);
            key_len_new   = (key_len_base < KEY_LENGTH_MAX) ? key_len_base + 4'd1
                                                            : key_len_base;
         end
      end
   end

   assign error_new = error_ff || bad;

   always_comb begin
      result.value_byte   = (valid && !bad) ? c : 8'h00;
      result.value_valid  = valid && !bad;
      result.value_end    = done_end && !bad;
      result.syntax_error = error_new;
      result.text_done    = item.is_last;
      result.text_ok      = item.is_last && !error_new && (phase_new == PH_IDLE);
   end

   // Re-arm after the last byte of a text
   always_comb begin
      if (item.is_last) begin
         phase_in     = PH_IDLE;
         key_len_in   = 4'd0;
         key_match_in = 1'b1;
         error_in     = 1'b0;
      end else begin
         phase_in     = phase_new;
         key_len_in   = key_len_new;
         key_match_in = key_match_new;
         error_in     = error_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         key_len_ff   <= 4'd0;
         key_match_ff <= 1'b1;
         error_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         key_len_ff   <= key_len_in;
         key_match_ff <= key_match_in;
         error_ff     <= error_in;
      end
   end

endmodule

### bench/tb_top.sv
// Testbench for key_value_config_byte_parser: directed and random config texts, byte by byte.
// Depends on kvcfg_pkg for the payload types and character codes; carries its own parser model.
module tb_top;
   import kvcfg_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 850;
   localparam logic [63:0] WANTED_KEY = 64'h6461_7461_5F64_6972;
   localparam logic [7:0] CHAR_VTAB = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED = 8'h0C;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_COMMENT,
      PARSE_KEY,
      PARSE_EQ,
      PARSE_VALUE,
      PARSE_BARE,
      PARSE_QUOTED
   } parse_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // parser model state
   parse_phase_type phase = PARSE_IDLE;
   logic [3:0]      key_len = '0;
   logic            key_match = 1'b1;
   logic            err_seen = 1'b0;

   rsp_type    expected_rsp_q[$];
   logic [7:0] text_q[$];
   rsp_type    want_rsp;
   int         mismatches = 0;
   int         bytes_sent = 0;
   string      key_text;

   // idling controls, written by the test tasks and send_text_byte only
   int gap_max = 0;
   int burst_left = 0;
   bit stall_enable = 1'b0;
   int hold_ticket = 0;

   // receiver-side counters
   int hold_taken = 0;
   int hold_left = 0;
   int stretch_left = 0;
   int stretch_pct = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   key_value_config_byte_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic logic char_is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic char_is_word(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c == CHAR_UNDER);
   endfunction

   function automatic void take_key_char(input logic [7:0] c);
      if (key_len >= KEY_LENGTH || WANTED_KEY[8 * (7 - int'(key_len[2:0])) +: 8] != c)
         key_match = 1'b0;
      if (key_len < KEY_LENGTH_MAX)
         key_len = key_len + 4'd1;
   endfunction

   // Advance the parser model by one byte and return the result it implies.
   function automatic rsp_type parse_text_byte(input req_type item);
      logic [7:0] c;
      logic       emit;
      logic       close;
      logic       bad;
      rsp_type    res;
      c = item.text_byte;
      emit = 1'b0;
      close = 1'b0;
      bad = 1'b0;
      if (!err_seen) begin
         case (phase)
            PARSE_IDLE: begin
               if (char_is_space(c)) begin
               end else if (c == CHAR_HASH) begin
                  phase = PARSE_COMMENT;
               end else if (char_is_word(c)) begin
                  key_len = '0;
                  key_match = 1'b1;
                  take_key_char(c);
                  phase = PARSE_KEY;
               end else begin
                  bad = 1'b1;
               end
            end
            PARSE_COMMENT: begin
               if (c == CHAR_NEWLINE)
                  phase = PARSE_IDLE;
            end
            PARSE_KEY: begin
               if (char_is_word(c)) begin
                  take_key_char(c);
               end else if (char_is_space(c) || c == CHAR_EQUAL) begin
                  if (!(key_match && key_len == KEY_LENGTH))
                     bad = 1'b1;
                  else
                     phase = (c == CHAR_EQUAL) ? PARSE_VALUE : PARSE_EQ;
               end else begin
                  bad = 1'b1;
               end
            end
            PARSE_EQ: begin
               if (char_is_space(c)) begin
               end else if (c == CHAR_EQUAL) begin
                  phase = PARSE_VALUE;
               end else begin
                  bad = 1'b1;
               end
            end
            PARSE_VALUE: begin
               if (char_is_space(c)) begin
               end else if (c == CHAR_QUOTE) begin
                  phase = PARSE_QUOTED;
               end else if (char_is_word(c)) begin
                  emit = 1'b1;
                  phase = PARSE_BARE;
               end else begin
                  bad = 1'b1;
               end
            end
            PARSE_BARE: begin
               if (char_is_word(c)) begin
                  emit = 1'b1;
               end else if (char_is_space(c)) begin
                  close = 1'b1;
                  phase = PARSE_IDLE;
               end else if (c == CHAR_HASH) begin
                  close = 1'b1;
                  phase = PARSE_COMMENT;
               end else begin
                  bad = 1'b1;
               end
            end
            PARSE_QUOTED: begin
               if (c == CHAR_QUOTE) begin
                  close = 1'b1;
                  phase = PARSE_IDLE;
               end else if (c == CHAR_NEWLINE || c == CHAR_BACKSLASH) begin
                  bad = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            err_seen = 1'b1;
            emit = 1'b0;
            close = 1'b0;
         end
      end
      res.value_byte = emit ? c : 8'h00;
      res.value_valid = emit;
      res.value_end = close;
      res.syntax_error = err_seen;
      res.text_done = item.is_last;
      res.text_ok = item.is_last && !err_seen && phase == PARSE_IDLE;
      // re-arm for the next text
      if (item.is_last) begin
         phase = PARSE_IDLE;
         key_len = '0;
         key_match = 1'b1;
         err_seen = 1'b0;
      end
      return res;
   endfunction

   function automatic logic [7:0] rand_word_char();
      int n;
      n = $urandom_range(0, 52);
      if (n < 26)
         return 8'("A" + n);
      else if (n < 52)
         return 8'("a" + n - 26);
      return CHAR_UNDER;
   endfunction

   function automatic logic [7:0] rand_blank_char();
      case ($urandom_range(0, 5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_NEWLINE;
         3: return CHAR_VTAB;
         4: return CHAR_FORMFEED;
         default: return CHAR_CR;
      endcase
   endfunction

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   task automatic push_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         text_q.push_back(rand_blank_char());
   endtask

   task automatic push_comment_body();
      logic [7:0] c;
      repeat ($urandom_range(0, 10)) begin
         do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
         text_q.push_back(c);
      end
   endtask

   task automatic push_entry();
      logic [7:0] c;
      push_blanks(0, 2);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 18))
            text_q.push_back(rand_word_char());
      end else begin
         push_str(key_text);
      end
      push_blanks(0, 2);
      text_q.push_back(CHAR_EQUAL);
      push_blanks(0, 2);
      if ($urandom_range(0, 1) == 1) begin
         repeat ($urandom_range(1, 10))
            text_q.push_back(rand_word_char());
         if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CHAR_HASH);
            push_comment_body();
         end else begin
            text_q.push_back(rand_blank_char());
         end
      end else begin
         text_q.push_back(CHAR_QUOTE);
         repeat ($urandom_range(0, 10)) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_QUOTE || c == CHAR_NEWLINE || c == CHAR_BACKSLASH);
            text_q.push_back(c);
         end
         text_q.push_back(CHAR_QUOTE);
      end
      text_q.push_back(CHAR_NEWLINE);
   endtask

   // Offer one byte and hold it until the block takes it.
   task automatic send_text_byte(input logic [7:0] b, input logic last);
      req_type item;
      item.text_byte = b;
      item.is_last = last;
      if (gap_max > 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(parse_text_byte(item));
      bytes_sent++;
   endtask

   task automatic send_text_q();
      for (int i = 0; i < text_q.size(); i++)
         send_text_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic send_str(input string s);
      push_str(s);
      send_text_q();
   endtask

   task automatic test_directed_texts();
      gap_max = 3;
      stall_enable = 1'b1;
      send_str({key_text, " = v_Z#c\n"});
      send_str({key_text, "\t=\"q x\""});
      send_str({key_text, "=a"});
      send_str({"D", key_text.substr(1, 7), "=x "});
      send_str({key_text.substr(0, 6), "=x "});
      send_str({key_text, "s=x "});
      send_str("abcdefghijklmnopqrst x");
      send_str({key_text, " x"});
      send_str({key_text, "==x"});
      send_str({key_text, "=a=b"});
      send_str({key_text, "=\"a\\b\""});
      send_str({key_text, "=\"a\nb\""});
      send_str("# open comment");
      send_str({key_text, "=\"open"});
      // high and control bytes inside a quoted value
      push_str({key_text, "=\""});
      text_q.push_back(8'h80);
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      text_q.push_back(8'h7F);
      push_str("\"\n");
      send_text_q();
      // error first, then a good line that must stay frozen
      text_q.push_back(8'hFF);
      send_str({key_text, "=x\n"});
      text_q.push_back(CHAR_VTAB);
      text_q.push_back(CHAR_FORMFEED);
      send_str("\r \n");
      send_text_byte(8'h00, 1'b1);
   endtask

   task automatic test_receiver_hold_off();
      gap_max = 0;
      stall_enable = 1'b0;
      hold_ticket++;
      repeat (4) push_entry();
      send_text_q();
   endtask

   task automatic build_random_text();
      int pick;
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            text_q.push_back(CHAR_HASH);
            push_comment_body();
            text_q.push_back(CHAR_NEWLINE);
         end else if (pick == 2) begin
            push_blanks(1, 3);
         end else begin
            push_entry();
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
         pick = $urandom_range(1, text_q.size());
         while (text_q.size() > pick)
            void'(text_q.pop_back());
      end else if (pick < 18) begin
         text_q.delete();
         repeat ($urandom_range(1, 20))
            text_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_texts();
      int stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: gap_max = 0;
               1: gap_max = 2;
               default: gap_max = 10;
            endcase
            stall_enable = 1'($urandom_range(0, 1));
         end
         build_random_text();
         send_text_q();
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type exp, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected byte %h valid %b end %b err %b done %b ok %b",
                  $realtime, what, exp.value_byte, exp.value_valid, exp.value_end,
                  exp.syntax_error, exp.text_done, exp.text_ok);
         $display("%0t %s: got      byte %h valid %b end %b err %b done %b ok %b",
                  $realtime, what, got.value_byte, got.value_valid, got.value_end,
                  got.syntax_error, got.text_done, got.text_ok);
      end
   endtask

   // receiver: random stretches of stalling, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_ticket != hold_taken) begin
         hold_taken = hold_ticket;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
               0: stretch_pct = 0;
               1: stretch_pct = 25;
               default: stretch_pct = 75;
            endcase
         end
         stretch_left--;
         rsp_stall <= stall_enable && ($urandom_range(0, 99) < stretch_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_data);
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (rsp_data !== want_rsp)
               note_mismatch("result mismatch", want_rsp, rsp_data);
         end
      end
   end

   // end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      key_text = $sformatf("%s", WANTED_KEY);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_texts();
      test_receiver_hold_off();
      test_random_texts();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
